// File: design/cht_pkg.sv
// Shared types and constants for the coalesced hash table.
// No dependencies; imported by every module of the block.
package cht_pkg;

    localparam int KEY_W        = 31;
    localparam int STATUS_W     = 3;
    localparam int SLOT_OUT_W   = 6;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 16;

    // Modulo unit: bits folded in per cycle and number of cycles (covers KEY_W + 1 bits).
    localparam int MOD_BITS     = 4;
    localparam int MOD_STEPS    = 8;
    localparam int MOD_SHIFT_W  = MOD_BITS * MOD_STEPS;
    localparam int MOD_CNT_W    = $clog2(MOD_STEPS);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

endpackage

// File: design/cht_mod.sv
// Iterative key-modulo-table-size unit, MOD_BITS key bits per cycle.
// Depends on cht_pkg.
module cht_mod
    import cht_pkg::*;
#(
    parameter int TABLE_SLOTS = 64,
    parameter int IDX_W       = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [IDX_W-1:0] rem
);

    logic [MOD_SHIFT_W-1:0] sh_reg;
    logic [IDX_W-1:0]       rem_reg;
    logic [IDX_W-1:0]       rem_next;
    logic [MOD_CNT_W-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    always_comb
    begin
        logic [IDX_W:0] t;
        logic [IDX_W-1:0] r;
        r = rem_reg;
        for (int b = 0; b < MOD_BITS; b++)
        begin
            t = {r, sh_reg[MOD_SHIFT_W-1-b]};
            if (t >= (IDX_W+1)'(TABLE_SLOTS))
            begin
                t = t - (IDX_W+1)'(TABLE_SLOTS);
            end
            r = t[IDX_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= MOD_SHIFT_W'(key);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << MOD_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: design/cht_ram.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on cht_pkg.
module cht_ram
    import cht_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 39
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/coalesced_hash_table.sv
// Top level of the coalesced hash table: control sequencer, slot memory, modulo unit.
// Depends on cht_pkg, cht_mod and cht_ram.
//
// channel  dir  fields (lsb first)                    accepted when
// s_*      in   s_tdata: opcode[0], key[31:1]         s_tvalid && s_tready
// m_*      out  m_tdata: status[2:0], slot_index[8:3] m_tvalid && m_tready
//
// Per request: accept, home slot from the low key bits (power-of-two table) or from
// the modulo unit, a read per chain slot, a read per slot scanned for a free entry,
// 1 or 2 memory writes, then the result is loaded into the output register.
// After reset a clearing pass zeroes every slot before s_tready rises.
// A held result stalls only the S_FINISH state of the next request.
module coalesced_hash_table
    import cht_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // opcode, key
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status, slot_index, zero pad
);

    localparam int  IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int  LINK_W  = $clog2(TABLE_SLOTS + 1);
    localparam int  ENT_W   = 1 + KEY_W + LINK_W;
    localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_WALK,
        S_SCAN,
        S_WR_NEW,
        S_WR_LINK,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      new_reg;
    logic [KEY_W-1:0]      tail_key_reg;
    logic                  first_reg;
    logic                  link_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [IDX_W-1:0]      res_index_reg;
    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [SLOT_OUT_W-1:0] m_index_reg;

    logic                  in_op;
    logic [KEY_W-1:0]      in_key;
    logic                  accept;
    logic                  mod_start;
    logic                  mod_done;
    logic [IDX_W-1:0]      mod_rem;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENT_W-1:0]      rd_data;
    logic                  rd_used;
    logic [KEY_W-1:0]      rd_key;
    logic [LINK_W-1:0]     rd_link;
    logic                  key_hit;
    logic                  link_end;

    assign in_op    = s_tdata[0];
    assign in_key   = s_tdata[KEY_W:1];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign rd_used  = rd_data[ENT_W-1];
    assign rd_key   = rd_data[ENT_W-2 -: KEY_W];
    assign rd_link  = rd_data[LINK_W-1:0];
    assign key_hit  = (rd_key == key_reg);
    assign link_end = (rd_link >= LINK_END);

    assign mod_start = accept && !IS_POW2;

    cht_mod #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (in_key),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    cht_ram #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Read address and write port, from the state and the entry just read.
    always_comb
    begin
        rd_addr = cur_reg;
        wr_en   = 1'b0;
        wr_addr = new_reg;
        wr_data = {1'b1, key_reg, LINK_END};
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = '0;
            end
            S_IDLE:
            begin
                rd_addr = in_key[IDX_W-1:0];
            end
            S_MOD:
            begin
                rd_addr = mod_rem;
            end
            S_WALK:
            begin
                if (!rd_used)
                begin
                    rd_addr = new_reg;
                end
                else if (!link_end)
                begin
                    rd_addr = rd_link[IDX_W-1:0];
                end
            end
            S_SCAN:
            begin
                rd_addr = cur_reg + 1'b1;
            end
            S_WR_NEW:
            begin
                wr_en = 1'b1;
            end
            S_WR_LINK:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {1'b1, tail_key_reg, LINK_W'(new_reg)};
            end
            S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cur_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            new_reg        <= '0;
            tail_key_reg   <= '0;
            first_reg      <= 1'b0;
            link_reg       <= 1'b0;
            res_status_reg <= STAT_INSERTED;
            res_index_reg  <= '0;
            m_status_reg   <= STAT_INSERTED;
            m_index_reg    <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    cur_reg <= cur_reg + 1'b1;
                    if (cur_reg == IDX_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= in_op;
                        key_reg   <= in_key;
                        first_reg <= 1'b1;
                        link_reg  <= 1'b0;
                        cur_reg   <= in_key[IDX_W-1:0];
                        state_reg <= IS_POW2 ? S_WALK : S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        cur_reg   <= mod_rem;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    first_reg <= 1'b0;
                    priority if (!rd_used)
                    begin
                        if (op_reg == OP_FIND)
                        begin
                            res_status_reg <= STAT_NOT_FOUND;
                            res_index_reg  <= '0;
                            state_reg      <= S_FINISH;
                        end
                        else if (first_reg)
                        begin
                            new_reg   <= cur_reg;
                            state_reg <= S_WR_NEW;
                        end
                        else
                        begin
                            // free link target: rescan from the tail
                            cur_reg   <= new_reg;
                            state_reg <= S_SCAN;
                        end
                    end
                    else if (key_hit)
                    begin
                        res_status_reg <= (op_reg == OP_FIND) ? STAT_FOUND : STAT_DUPLICATE;
                        res_index_reg  <= (op_reg == OP_FIND) ? cur_reg : '0;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        tail_key_reg <= rd_key;
                        new_reg      <= cur_reg;
                        if (link_end)
                        begin
                            if (op_reg == OP_FIND)
                            begin
                                res_status_reg <= STAT_NOT_FOUND;
                                res_index_reg  <= '0;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        else
                        begin
                            cur_reg <= rd_link[IDX_W-1:0];
                        end
                    end
                end
                S_SCAN:
                begin
                    // new_reg holds the tail, cur_reg the slot whose entry is in rd_data
                    if (!rd_used)
                    begin
                        link_reg  <= 1'b1;
                        new_reg   <= cur_reg;
                        cur_reg   <= new_reg;
                        state_reg <= S_WR_NEW;
                    end
                    else if (cur_reg == IDX_LAST)
                    begin
                        res_status_reg <= STAT_FULL;
                        res_index_reg  <= '0;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + 1'b1;
                    end
                end
                S_WR_NEW:
                begin
                    res_status_reg <= STAT_INSERTED;
                    res_index_reg  <= new_reg;
                    state_reg      <= link_reg ? S_WR_LINK : S_FINISH;
                end
                S_WR_LINK:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_index_reg  <= SLOT_OUT_W'(res_index_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({m_index_reg, m_status_reg});

    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !wr_en)
        else $error("memory write during request accept");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == STAT_INSERTED || m_tdata[2:0] == STAT_DUPLICATE ||
                      m_tdata[2:0] == STAT_FULL || m_tdata[2:0] == STAT_FOUND ||
                      m_tdata[2:0] == STAT_NOT_FOUND))
        else $error("illegal status code");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == STAT_DUPLICATE || m_tdata[2:0] == STAT_FULL ||
                      m_tdata[2:0] == STAT_NOT_FOUND)) |-> (m_tdata[8:3] == '0))
        else $error("slot index not zero on miss");

endmodule
